// ===== design/crc16w_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package crc16w_pkg;

	// CRC polynomial and masks.
	localparam logic [15:0] CRC_POLY = 16'h100b;
	localparam logic [15:0] CRC_TOP  = 16'h8000;
	localparam logic [15:0] CRC_MASK = 16'hffff;
	localparam logic [15:0] CRC_RESET_START = 16'hffff;

	localparam int unsigned WORD_BITS = 32;
	localparam int unsigned CRC_BITS  = 16;

	// Command codes carried in tuser.
	typedef enum logic [1:0] {
		CMD_ADD     = 2'd0,
		CMD_FINISH  = 2'd1,
		CMD_RESTART = 2'd2
	} cmd_t;

	// One column of the linear update per input bit.
	typedef logic [CRC_BITS-1:0][CRC_BITS-1:0]  crc_cols_t;
	typedef logic [WORD_BITS-1:0][CRC_BITS-1:0] word_cols_t;

	// One step of the serial shift register.
	function automatic logic [15:0] shift_bit(input logic [15:0] r, input logic b);
		logic [15:0] nxt;
		nxt = {r[14:0], b};
		if ((r & CRC_TOP) != 16'h0000) begin
			nxt = nxt ^ CRC_POLY;
		end
		return nxt;
	endfunction

	// Effect of each register bit after 32 shifted-in data bits.
	function automatic crc_cols_t add_crc_cols();
		crc_cols_t cols;
		logic [15:0] r;
		for (int i = 0; i < CRC_BITS; i++) begin
			r = 16'h0001 << i;
			for (int s = 0; s < WORD_BITS; s++) begin
				r = shift_bit(r, 1'b0);
			end
			cols[i] = r;
		end
		return cols;
	endfunction

	// Effect of each data bit, shifted in most significant bit first.
	function automatic word_cols_t add_word_cols();
		word_cols_t cols;
		logic [15:0] r;
		logic [31:0] w;
		for (int k = 0; k < WORD_BITS; k++) begin
			r = 16'h0000;
			w = 32'h0000_0001 << k;
			for (int s = 0; s < WORD_BITS; s++) begin
				r = shift_bit(r, w[WORD_BITS-1-s]);
			end
			cols[k] = r;
		end
		return cols;
	endfunction

	// Effect of each register bit after 16 augmenting zero bits.
	function automatic crc_cols_t fin_crc_cols();
		crc_cols_t cols;
		logic [15:0] r;
		for (int i = 0; i < CRC_BITS; i++) begin
			r = 16'h0001 << i;
			for (int s = 0; s < CRC_BITS; s++) begin
				r = shift_bit(r, 1'b0);
			end
			cols[i] = r;
		end
		return cols;
	endfunction

endpackage

`default_nettype wire

// ===== design/crc16_word_engine.sv =====
// Path: a beat accepted into the input register stage moves on into the CRC register,
// which is offered on the master side, once that register is free or is being read.
// Throughput: one beat per cycle while the master side is not stalled; the CRC register
// closes its loop through one unrolled 32-bit XOR network.
// Reset: arst_n clears both stages and sets start_value and the CRC register
// to 0xffff.
`timescale 1ns / 1ps
`default_nettype none

module crc16_word_engine (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         cfg_we,
	input  wire  [15:0] cfg_wdata,      // start_value
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	input  wire  [31:0] s_axis_tdata,   // [31:0] data_word
	input  wire  [1:0]  s_axis_tuser,   // [1:0] cmd
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	output logic [15:0] m_axis_tdata    // [15:0] crc_value
);
	import crc16w_pkg::*;

	logic        valid_s1;
	cmd_t        cmd_s1;
	logic [31:0] word_s1;
	logic [15:0] crc_q;
	logic [15:0] start_q;
	logic        m_valid_q;
	logic [15:0] crc_next;
	logic        adv;
	logic        in_acc;

	// The input stage moves on when the result register is free or is being read.
	assign adv           = valid_s1 && (!m_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || adv;
	assign in_acc        = s_axis_tvalid && s_axis_tready;

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= CRC_RESET_START;
		end else if (cfg_we) begin
			start_q <= cfg_wdata;
		end
	end

	// Input register stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			cmd_s1  <= cmd_t'(s_axis_tuser);
			word_s1 <= s_axis_tdata;
		end
	end

	crc16w_update u_update (
		.cmd         (cmd_s1),
		.data_word   (word_s1),
		.crc         (crc_q),
		.start_value (start_q),
		.crc_next    (crc_next)
	);

	// CRC register doubles as the result register; it only changes on advance.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q     <= CRC_RESET_START;
			m_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				crc_q <= crc_next;
			end
			if (adv) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = crc_q;

	// A result waiting on the master side must not be overwritten.
	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		(m_valid_q && !m_axis_tready) |=> $stable(crc_q))
		else $error("CRC result changed while stalled");

	// A beat in the input stage stays until it advances.
	a_hold_input: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv) |=> valid_s1)
		else $error("input stage beat lost");

	// Every advance produces a result beat.
	a_adv_out: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> m_valid_q)
		else $error("advance without result");

	// Restart loads the configured start value.
	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && cmd_s1 == CMD_RESTART) |=> (crc_q == $past(start_q)))
		else $error("restart did not load start value");

endmodule

`default_nettype wire

// ===== design/crc16w_update.sv =====
`timescale 1ns / 1ps
`default_nettype none

module crc16w_update (
	input  var crc16w_pkg::cmd_t cmd,
	input  wire  [31:0]          data_word,
	input  wire  [15:0]          crc,
	input  wire  [15:0]          start_value,
	output logic [15:0]          crc_next
);
	import crc16w_pkg::*;

	// Column tables of the unrolled shift network, fixed at elaboration.
	localparam crc_cols_t  ADD_CRC  = add_crc_cols();
	localparam word_cols_t ADD_WORD = add_word_cols();
	localparam crc_cols_t  FIN_CRC  = fin_crc_cols();

	logic [15:0] add_val;
	logic [15:0] fin_val;

	// XOR together the columns of every set input bit.
	always_comb begin
		add_val = 16'h0000;
		fin_val = 16'h0000;
		for (int i = 0; i < CRC_BITS; i++) begin
			if (crc[i]) begin
				add_val = add_val ^ ADD_CRC[i];
				fin_val = fin_val ^ FIN_CRC[i];
			end
		end
		for (int k = 0; k < WORD_BITS; k++) begin
			if (data_word[k]) begin
				add_val = add_val ^ ADD_WORD[k];
			end
		end
	end

	// Select the result by command; the unused code keeps the register.
	always_comb begin
		unique case (cmd)
			CMD_ADD:     crc_next = add_val;
			CMD_FINISH:  crc_next = fin_val ^ CRC_MASK;
			CMD_RESTART: crc_next = start_value;
			default:     crc_next = crc;
		endcase
	end

endmodule

`default_nettype wire
